/* hdl/tcr_pkg.sv */
// ----------------------------------------------------------------------------
// tcr_pkg
// shared types and constants for the throttle command ramp
// ----------------------------------------------------------------------------
package tcr_pkg;

    typedef enum logic [1:0] {
        FUNC_CMD        = 2'd0,
        FUNC_CONNECT    = 2'd1,
        FUNC_DISCONNECT = 2'd2,
        FUNC_TICK       = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_RAMP_UP   = 2'd0,
        CFG_RAMP_DOWN = 2'd1,
        CFG_DEADBAND  = 2'd2,
        CFG_MAX_ANGLE = 2'd3
    } cfg_idx_t;

    localparam logic [7:0] CMD_FULL = 8'h31;
    localparam logic [7:0] CMD_ZERO = 8'h30;

    localparam logic [15:0] RESET_RAMP_UP   = 16'd461;
    localparam logic [15:0] RESET_RAMP_DOWN = 16'd3072;
    localparam logic [7:0]  RESET_DEADBAND  = 8'd5;
    localparam logic [7:0]  RESET_MAX_ANGLE = 8'd180;

    typedef struct packed {
        logic [15:0] ramp_up_step;
        logic [15:0] ramp_down_step;
        logic [7:0]  deadband;
        logic [7:0]  max_angle;
    } cfg_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] cmd_byte;
    } event_t;

endpackage

/* hdl/throttle_command_ramp_unit.sv */
// ----------------------------------------------------------------------------
// throttle_command_ramp_unit
// asymmetric slew limiter that ramps a throttle level toward a commanded target
//
//   channel   signals                          direction
//   in        in_valid, in_stall, func,        event in, one per transfer
//             cmd_byte
//   out       out_valid, out_stall,            one result per event
//             throttle_angle, link_up
//   cfg       cfg_we, cfg_index, cfg_data      register write, no read-back
//
// an event moves from the input register straight into the result register,
// so one event per cycle is sustained while out_stall stays low.
// the slew state updates in the same cycle the event leaves the input register.
// rst_n clears the valid flags and the slew state and loads the register defaults.
// out_stall holds the result register; while an event waits in the input
// register and the result register is full, in_stall follows out_stall in the same cycle.
// ----------------------------------------------------------------------------
module throttle_command_ramp_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  cmd_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  throttle_angle,
    output logic        link_up,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tcr_pkg::cfg_t   cfg;
    tcr_pkg::event_t ev;
    logic            ev_valid;
    logic            advance;

    tcr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .cmd_byte (cmd_byte),
        .advance  (advance),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    tcr_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .ev_valid       (ev_valid),
        .ev             (ev),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .throttle_angle (throttle_angle),
        .link_up        (link_up)
    );

endmodule

/* hdl/tcr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tcr_cfg_regs
// configuration register bank written through a plain write port
// ----------------------------------------------------------------------------
module tcr_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output tcr_pkg::cfg_t       cfg
);

    tcr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_up_step   <= tcr_pkg::RESET_RAMP_UP;
            cfg_reg.ramp_down_step <= tcr_pkg::RESET_RAMP_DOWN;
            cfg_reg.deadband       <= tcr_pkg::RESET_DEADBAND;
            cfg_reg.max_angle      <= tcr_pkg::RESET_MAX_ANGLE;
        end
        else if (cfg_we)
        begin
            case (tcr_pkg::cfg_idx_t'(cfg_index))
                tcr_pkg::CFG_RAMP_UP:   cfg_reg.ramp_up_step   <= cfg_data;
                tcr_pkg::CFG_RAMP_DOWN: cfg_reg.ramp_down_step <= cfg_data;
                tcr_pkg::CFG_DEADBAND:  cfg_reg.deadband       <= cfg_data[7:0];
                tcr_pkg::CFG_MAX_ANGLE: cfg_reg.max_angle      <= cfg_data[7:0];
                default:                cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/tcr_in_stage.sv */
// ----------------------------------------------------------------------------
// tcr_in_stage
// input register for one event, held while the update stage is blocked
// ----------------------------------------------------------------------------
module tcr_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [7:0]          cmd_byte,
    input  logic                advance,
    output logic                ev_valid,
    output tcr_pkg::event_t     ev
);

    logic            valid_reg;
    tcr_pkg::event_t ev_reg;

    // stage may load when empty or when its event moves on this cycle
    assign in_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            ev_reg.func     <= tcr_pkg::func_t'(func);
            ev_reg.cmd_byte <= cmd_byte;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

/* hdl/tcr_core.sv */
// ----------------------------------------------------------------------------
// tcr_core
// target mapping, slew step and clamp, with state and result registers
// ----------------------------------------------------------------------------
module tcr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tcr_pkg::cfg_t       cfg,
    input  logic                ev_valid,
    input  tcr_pkg::event_t     ev,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          throttle_angle,
    output logic                link_up
);

    logic [15:0] current_reg;
    logic [15:0] current_next;
    logic [7:0]  target_reg;
    logic [7:0]  target_next;
    logic        connected_reg;
    logic        connected_next;
    logic        out_valid_reg;
    logic [7:0]  angle_reg;
    logic        link_reg;

    logic [15:0] product;
    logic [16:0] recip_sum;
    logic [7:0]  mapped;
    logic [15:0] tgt_q;
    logic [15:0] lim_q;
    logic [16:0] up_sum;
    logic [15:0] down_gap;
    logic [15:0] stepped;

    assign advance = ev_valid && (!out_valid_reg || !out_stall);

    // floor(p / 255) for p <= 255*255 as (p + (p >> 8) + 1) >> 8
    assign product   = 16'(ev.cmd_byte) * 16'(cfg.max_angle);
    assign recip_sum = 17'(product) + 17'(product[15:8]) + 17'd1;

    always_comb
    begin
        if (ev.cmd_byte == tcr_pkg::CMD_FULL)
        begin
            mapped = cfg.max_angle;
        end
        else if (ev.cmd_byte == tcr_pkg::CMD_ZERO || ev.cmd_byte < cfg.deadband)
        begin
            mapped = 8'd0;
        end
        else
        begin
            mapped = recip_sum[15:8];
        end
    end

    assign tgt_q    = {target_reg, 8'd0};
    assign lim_q    = {cfg.max_angle, 8'd0};
    assign up_sum   = 17'(current_reg) + 17'(cfg.ramp_up_step);
    assign down_gap = current_reg - tgt_q;

    // step toward target, never past it, then clamp to the angle limit
    always_comb
    begin
        stepped = current_reg;
        if (current_reg < tgt_q)
        begin
            if (up_sum > 17'(tgt_q))
                stepped = tgt_q;
            else
                stepped = up_sum[15:0];
        end
        else if (current_reg > tgt_q)
        begin
            if (down_gap < cfg.ramp_down_step)
                stepped = tgt_q;
            else
                stepped = current_reg - cfg.ramp_down_step;
        end
        if (stepped > lim_q)
            stepped = lim_q;
    end

    always_comb
    begin
        current_next   = current_reg;
        target_next    = target_reg;
        connected_next = connected_reg;
        case (ev.func)
            tcr_pkg::FUNC_CMD:
            begin
                target_next = mapped;
            end
            tcr_pkg::FUNC_CONNECT:
            begin
                connected_next = 1'b1;
            end
            tcr_pkg::FUNC_DISCONNECT:
            begin
                connected_next = 1'b0;
                target_next    = 8'd0;
            end
            tcr_pkg::FUNC_TICK:
            begin
                if (connected_reg)
                begin
                    current_next = stepped;
                end
                else
                begin
                    current_next = 16'd0;
                    target_next  = 8'd0;
                end
            end
            default:
            begin
                current_next = current_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg   <= 16'd0;
            target_reg    <= 8'd0;
            connected_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                current_reg   <= current_next;
                target_reg    <= target_next;
                connected_reg <= connected_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            angle_reg <= current_next[15:8];
            link_reg  <= connected_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign throttle_angle = angle_reg;
    assign link_up        = link_reg;

endmodule

/* tb/sv/tb_throttle_command_ramp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_throttle_command_ramp_unit
// self-checking regression for the throttle command ramp
//
// events go in over a valid/stall channel in random bursts while the result
// channel stalls in random runs. each accepted event updates a local copy of
// the slew state, and the expected angle and link flag are queued. every result
// transfer is checked against the oldest queued entry. register settings are
// changed only once the block has drained, and include the range extremes and
// zero steps.
// ----------------------------------------------------------------------------
module tb_throttle_command_ramp_unit;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] angle;
        logic       link;
    } throttle_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    tcr_pkg::func_t    ev_func = tcr_pkg::FUNC_CMD;
    logic [7:0]        ev_cmd = 8'd0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        throttle_angle;
    logic              link_up;
    logic              cfg_we = 1'b0;
    tcr_pkg::cfg_idx_t cfg_sel = tcr_pkg::CFG_RAMP_UP;
    logic [15:0]       cfg_wdata = 16'd0;

    // local copy of the registers and slew state
    logic [15:0] up_step = tcr_pkg::RESET_RAMP_UP;
    logic [15:0] down_step = tcr_pkg::RESET_RAMP_DOWN;
    logic [7:0]  dead_zone = tcr_pkg::RESET_DEADBAND;
    logic [7:0]  angle_limit = tcr_pkg::RESET_MAX_ANGLE;
    logic [15:0] level_q88 = 16'd0;
    logic [7:0]  goal_deg = 8'd0;
    logic        link_state = 1'b0;

    throttle_result_t expected_results[$];

    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int events_sent = 0;
    int ticks_sent = 0;
    int settings_used = 1;

    // sender and receiver pacing
    int gap_max = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_run_left = 0;
    logic stall_now = 1'b0;

    throttle_command_ramp_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (ev_func),
        .cmd_byte       (ev_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .throttle_angle (throttle_angle),
        .link_up        (link_up),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_sel),
        .cfg_data       (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_results.size());
            $display("throttle_command_ramp_unit regression: fail");
            $finish;
        end
    end

    // result side stalls in runs of random length
    always @(negedge clk)
    begin
        if (stall_run_left == 0)
        begin
            stall_now = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
            stall_run_left = $urandom_range(1, 6);
        end
        else
            stall_run_left--;
        out_stall = stall_now;
    end

    // ------------------------------------------------------------------------
    // slew prediction
    // ------------------------------------------------------------------------
    function automatic logic [7:0] target_for_cmd(input logic [7:0] cmd);
        logic [31:0] scaled;
        scaled = (32'(cmd) * 32'(angle_limit)) / 32'd255;
        if (cmd == tcr_pkg::CMD_FULL)
            return angle_limit;
        if (cmd == tcr_pkg::CMD_ZERO)
            return 8'd0;
        if (cmd < dead_zone)
            return 8'd0;
        return scaled[7:0];
    endfunction

    function automatic throttle_result_t apply_event(input tcr_pkg::func_t f,
                                                     input logic [7:0] cmd);
        logic [31:0] lvl;
        logic [31:0] goal;
        logic [31:0] ceiling;
        throttle_result_t r;
        lvl = 32'(level_q88);
        goal = 32'(goal_deg) << 8;
        ceiling = 32'(angle_limit) << 8;
        case (f)
            tcr_pkg::FUNC_CMD:        goal_deg = target_for_cmd(cmd);
            tcr_pkg::FUNC_CONNECT:    link_state = 1'b1;
            tcr_pkg::FUNC_DISCONNECT:
            begin
                link_state = 1'b0;
                goal_deg = 8'd0;
            end
            default:
            begin
                // step toward the goal without overshoot, then clamp
                if (lvl < goal)
                begin
                    lvl = lvl + 32'(up_step);
                    if (lvl > goal)
                        lvl = goal;
                end
                else if (lvl > goal)
                begin
                    if (lvl - goal < 32'(down_step))
                        lvl = goal;
                    else
                        lvl = lvl - 32'(down_step);
                end
                if (lvl > ceiling)
                    lvl = ceiling;
                if (!link_state)
                begin
                    goal_deg = 8'd0;
                    lvl = 32'd0;
                end
                level_q88 = lvl[15:0];
            end
        endcase
        r.angle = level_q88[15:8];
        r.link = link_state;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        throttle_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transfer with nothing pending at cycle %0d: angle %0d link %0d",
                             cycle_count, throttle_angle, link_up);
            end
            else
            begin
                want = expected_results.pop_front();
                if (throttle_angle !== want.angle)
                    flag_mismatch("throttle_angle", want.angle, throttle_angle);
                if (link_up !== want.link)
                    flag_mismatch("link_up", want.link, link_up);
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers, all called at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_event(input tcr_pkg::func_t f, input logic [7:0] cmd);
        in_valid = 1'b1;
        ev_func = f;
        ev_cmd = cmd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_event(f, cmd));
        events_sent++;
        if (f == tcr_pkg::FUNC_TICK)
            ticks_sent++;
        @(negedge clk);
        if (gap_max != 0)
        begin
            if (burst_left == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge clk);
                burst_left = $urandom_range(1, 10);
            end
            else
                burst_left--;
        end
    endtask

    task automatic drain_results;
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input tcr_pkg::cfg_idx_t idx, input logic [15:0] val);
        cfg_we = 1'b1;
        cfg_sel = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            tcr_pkg::CFG_RAMP_UP:   up_step = val;
            tcr_pkg::CFG_RAMP_DOWN: down_step = val;
            tcr_pkg::CFG_DEADBAND:  dead_zone = val[7:0];
            default:                angle_limit = val[7:0];
        endcase
    endtask

    task automatic program_regs(input logic [15:0] up, input logic [15:0] down,
                                input logic [7:0] dz, input logic [7:0] lim);
        drain_results();
        write_reg(tcr_pkg::CFG_RAMP_UP, up);
        write_reg(tcr_pkg::CFG_RAMP_DOWN, down);
        write_reg(tcr_pkg::CFG_DEADBAND, {8'd0, dz});
        write_reg(tcr_pkg::CFG_MAX_ANGLE, {8'd0, lim});
        settings_used++;
    endtask

    task automatic pick_pacing;
        if ($urandom_range(0, 3) == 0)
        begin
            gap_max = 0;
            stall_pct = 0;
        end
        else
        begin
            gap_max = $urandom_range(1, 8);
            stall_pct = $urandom_range(10, 70);
        end
        burst_left = $urandom_range(1, 10);
    endtask

    function automatic logic [15:0] pick_step();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'd1;
            1:       return 16'd46080;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(32, 4096));
        endcase
    endfunction

    function automatic logic [7:0] pick_cmd();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return tcr_pkg::CMD_FULL;
            1:       return tcr_pkg::CMD_ZERO;
            2:       return dead_zone + 8'($urandom_range(0, 2)) - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly connect, set a target, then ticks; some drops and reconnects
    task automatic run_traffic(input int n);
        int pick;
        if ($urandom_range(0, 9) < 8)
            send_event(tcr_pkg::FUNC_CONNECT, 8'($urandom_range(0, 255)));
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_event(tcr_pkg::FUNC_CONNECT, 8'($urandom_range(0, 255)));
            else if (pick < 9)
                send_event(tcr_pkg::FUNC_DISCONNECT, 8'($urandom_range(0, 255)));
            else if (pick < 38)
                send_event(tcr_pkg::FUNC_CMD, pick_cmd());
            else
                send_event(tcr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_events;
        gap_max = 0;
        stall_pct = 0;
        // ticks while the link is down force everything to zero
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, 8'hFF);
        send_event(tcr_pkg::FUNC_TICK, 8'hFF);
        send_event(tcr_pkg::FUNC_CONNECT, 8'hAA);
        send_event(tcr_pkg::FUNC_CMD, 8'hFF);
        repeat (4) send_event(tcr_pkg::FUNC_TICK, 8'h55);
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::CMD_ZERO);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::CMD_FULL);
        pick_pacing();
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        // deadband edge on either side
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::RESET_DEADBAND - 8'd1);
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::RESET_DEADBAND);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, 8'h00);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        // disconnect clears the target but the level drops on the next tick
        send_event(tcr_pkg::FUNC_DISCONNECT, 8'h00);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CONNECT, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, 8'h80);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
    endtask

    task automatic test_limit_lowered;
        program_regs(16'd46080, tcr_pkg::RESET_RAMP_DOWN, tcr_pkg::RESET_DEADBAND,
                     tcr_pkg::RESET_MAX_ANGLE);
        send_event(tcr_pkg::FUNC_CONNECT, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::CMD_FULL);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        // limit drops under both the target and the current level
        drain_results();
        write_reg(tcr_pkg::CFG_MAX_ANGLE, 16'd90);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, 8'hFF);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::CMD_FULL);
        drain_results();
        write_reg(tcr_pkg::CFG_MAX_ANGLE, 16'd200);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::CMD_FULL);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        settings_used++;
    endtask

    task automatic test_config_extremes;
        program_regs(16'd1, 16'd1, 8'd0, 8'd1);
        pick_pacing();
        run_traffic(40);

        // ramp up with a huge step, then freeze with zero steps
        program_regs(16'd46080, 16'd46080, tcr_pkg::RESET_DEADBAND,
                     tcr_pkg::RESET_MAX_ANGLE);
        send_event(tcr_pkg::FUNC_CONNECT, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, 8'hC0);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        program_regs(16'd0, 16'd0, tcr_pkg::RESET_DEADBAND, tcr_pkg::RESET_MAX_ANGLE);
        pick_pacing();
        run_traffic(40);

        // deadband above the full-throttle code, widest steps and limit
        program_regs(16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
        send_event(tcr_pkg::FUNC_CONNECT, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, tcr_pkg::CMD_FULL);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, 8'hFF);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        send_event(tcr_pkg::FUNC_CMD, 8'hFE);
        send_event(tcr_pkg::FUNC_TICK, 8'h00);
        pick_pacing();
        run_traffic(40);

        // zero limit pins everything at zero
        program_regs(16'd46080, 16'd46080, 8'd0, 8'd0);
        pick_pacing();
        run_traffic(40);

        program_regs(16'd46080, 16'd1, 8'd16, tcr_pkg::RESET_MAX_ANGLE);
        pick_pacing();
        run_traffic(40);
    endtask

    task automatic test_random_traffic;
        logic [7:0] dz;
        logic [7:0] lim;
        for (int phase = 0; phase < 8; phase++)
        begin
            dz = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 16))
                                            : 8'($urandom_range(0, 255));
            lim = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 180))
                                             : 8'($urandom_range(0, 255));
            program_regs(pick_step(), pick_step(), dz, lim);
            pick_pacing();
            if (phase == 3)
            begin
                // hold the sender until the pipe is empty mid-phase
                run_traffic(30);
                drain_results();
                run_traffic(30);
            end
            else
                run_traffic(60);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_events();
        test_limit_lowered();
        test_config_extremes();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge clk);

        $display("covered %0d events (%0d ticks) across %0d register settings",
                 events_sent, ticks_sent, settings_used);
        $display("checked %0d result transfers, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("throttle_command_ramp_unit regression: pass");
        else
            $display("throttle_command_ramp_unit regression: fail");
        $finish;
    end

endmodule

/* files.f */
hdl/tcr_pkg.sv
hdl/tcr_cfg_regs.sv
hdl/tcr_in_stage.sv
hdl/tcr_core.sv
hdl/throttle_command_ramp_unit.sv
tb/sv/tb_throttle_command_ramp_unit.sv
